@@ hdl/hrsr_pkg.sv @@
// ---------------------------------------------------------------------------
// hrsr_pkg: heart rate spike repair package
// Widths, constants and the result record shared by the repair block.
// ---------------------------------------------------------------------------
package hrsr_pkg;

   localparam int GAP_DEPTH = 63;
   localparam int RATE_BITS = 8;
   localparam int TALLY_W   = 16;

   // gap length counts 0..GAP_DEPTH, store address 0..GAP_DEPTH-1
   localparam int LEN_W     = $clog2(GAP_DEPTH + 1);
   localparam int ADDR_W    = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
   // interpolation divisor is gap length plus one
   localparam int DEN_W     = $clog2(GAP_DEPTH + 2);
   // running remainder stays below four times the divisor
   localparam int REM_W     = DEN_W + 2;
   localparam int DIV_CNT_W = $clog2(RATE_BITS);

   localparam logic [RATE_BITS-1:0] LIMIT_RESET = RATE_BITS'(200);
   localparam logic [TALLY_W-1:0]   TALLY_MAX   = '1;

   typedef logic [RATE_BITS-1:0] rate_type;

   typedef struct packed {
      logic [TALLY_W-1:0] replaced_total;
      logic               recording_done;
      logic               run_last;
      logic               replaced;
      rate_type           value;
   } rsp_type;

endpackage

@@ hdl/heart_rate_spike_repair.sv @@
// ---------------------------------------------------------------------------
// heart_rate_spike_repair: outlier gap repair by linear interpolation
// Repairs a stream of heart-rate samples; bad samples wait in a gap memory.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one raw sample per request; req_tlast marks the final
//    sample of a recording. A request is taken only while the block is idle.
//  - rsp_* returns repaired samples through one output register; rsp_tlast
//    closes the results of one request, rsp_tuser[1] closes the recording
//    and then rsp_tdata[23:8] holds the saturating replaced count.
//  - csr_* writes the upper limit (reset 200); write it while idle.
// Sequence:
//  - a good sample after no gap: ST_GOOD registers the result, then the
//    block is idle again and takes the next request
//  - a good sample after a gap of n with an anchor: a restoring divider,
//    then one result per cycle for the n fills and the sample, barring stalls
//  - a flush (store full or recording end) reads the gap memory entry by
//    entry, each through ST_FLUSH_RD (read address) and ST_FLUSH (read data)
//  - a bad sample that causes no result passes through ST_STORE to idle
// Reset clears the anchor, gap length and tally; the gap memory is not
// cleared since only written entries are ever read. A stalled rsp_tready
// holds the output register and the emitting states; the next request is
// accepted while the last result of the previous one still waits.
// ---------------------------------------------------------------------------
module heart_rate_spike_repair
   import hrsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] sample
   input  logic                 req_tlast,   // stream_end

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [7:0] value, [23:8] replaced_total
   output logic [1:0]           rsp_tuser,   // [0] replaced, [1] recording_done
   output logic                 rsp_tlast,   // run_last

   input  logic                 csr_tvalid,
   output logic                 csr_tready,
   input  logic [7:0]           csr_tdata    // upper_limit
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIVIDE, ST_FILL, ST_GOOD, ST_FLUSH_RD, ST_FLUSH, ST_STORE
   } state_type;

   state_type              state_ff, state_in;
   rate_type               limit_ff, limit_in;
   rate_type               smp_ff, smp_in;
   logic                   end_ff, end_in;
   logic                   stored_ff, stored_in;
   rate_type               anchor_ff, anchor_in;
   logic                   seen_ff, seen_in;
   logic                   rising_ff, rising_in;
   logic [LEN_W-1:0]       pend_ff, pend_in;
   logic [LEN_W-1:0]       idx_ff, idx_in;
   logic [TALLY_W-1:0]     tally_ff, tally_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   rate_type               div_num_ff, div_num_in;
   logic [DEN_W-1:0]       div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   rate_type               q_ff, q_in;
   logic [REM_W-1:0]       r_ff, r_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   rate_type               mem [GAP_DEPTH];
   rate_type               mem_q_ff;
   logic                   mem_we;

   logic                   out_free;
   logic                   req_fire;
   logic                   good;
   rate_type               diff;
   logic [DEN_W:0]         rem_shift;
   logic                   qbit;
   logic [REM_W-1:0]       r_sum;
   logic [REM_W-1:0]       two_d;
   logic                   r_wrap;
   rate_type               q_step;
   logic                   flush_end;
   logic                   fill_end;
   logic                   emit;
   rsp_type                emit_rsp;
   logic [TALLY_W-1:0]     tally_inc;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_tready = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.replaced_total, rsp_ff.value};
   assign rsp_tuser  = {rsp_ff.recording_done, rsp_ff.replaced};
   assign rsp_tlast  = rsp_ff.run_last;

   assign good = (req_tdata != '0) && (req_tdata <= limit_ff);
   assign diff = (req_tdata >= anchor_ff) ? (req_tdata - anchor_ff)
                                          : (anchor_ff - req_tdata);

   // restoring divider step: |s - a| / (n + 1)
   assign rem_shift = {div_rem_ff, div_num_ff[RATE_BITS-1]};
   assign qbit      = (rem_shift >= {1'b0, den_ff});

   // incremental rounding: next fill = floor((2jD + d) / 2d)
   assign r_sum  = r_ff + REM_W'({div_rem_ff, 1'b0});
   assign two_d  = REM_W'({den_ff, 1'b0});
   assign r_wrap = (r_sum >= two_d);
   assign q_step = q_ff + div_num_ff + RATE_BITS'(r_wrap);

   assign fill_end  = ((idx_ff + LEN_W'(1)) == pend_ff);
   assign flush_end = fill_end;

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      smp_in       = smp_ff;
      end_in       = end_ff;
      stored_in    = stored_ff;
      anchor_in    = anchor_ff;
      seen_in      = seen_ff;
      rising_in    = rising_ff;
      pend_in      = pend_ff;
      idx_in       = idx_ff;
      tally_in     = tally_ff;
      den_in       = den_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_cnt_in   = div_cnt_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      mem_we       = 1'b0;
      emit         = 1'b0;
      emit_rsp     = '0;

      if (csr_tvalid && csr_tready) begin
         limit_in = csr_tdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               smp_in     = req_tdata;
               end_in     = req_tlast;
               stored_in  = 1'b0;
               idx_in     = '0;
               rising_in  = (req_tdata >= anchor_ff);
               den_in     = DEN_W'(pend_ff) + DEN_W'(1);
               div_num_in = diff;
               div_rem_in = '0;
               div_cnt_in = '0;
               if (good) begin
                  if (pend_ff == '0) begin
                     state_in = ST_GOOD;
                  end else if (seen_ff) begin
                     state_in = ST_DIVIDE;
                  end else begin
                     state_in = ST_FILL;
                  end
               end else if (pend_ff == LEN_W'(GAP_DEPTH)) begin
                  state_in = ST_FLUSH_RD;
               end else begin
                  state_in = ST_STORE;
               end
            end
         end

         ST_DIVIDE: begin
            div_num_in = {div_num_ff[RATE_BITS-2:0], qbit};
            div_rem_in = qbit ? DEN_W'(rem_shift - {1'b0, den_ff}) : DEN_W'(rem_shift);
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(RATE_BITS - 1)) begin
               q_in     = '0;
               r_in     = REM_W'(den_ff);
               state_in = ST_FILL;
            end
         end

         ST_FILL: begin
            if (out_free) begin
               emit              = 1'b1;
               emit_rsp.replaced = 1'b1;
               if (seen_ff) begin
                  emit_rsp.value = rising_ff ? (anchor_ff + q_step) : (anchor_ff - q_step);
               end else begin
                  emit_rsp.value = smp_ff;
               end
               q_in   = q_step;
               r_in   = r_wrap ? (r_sum - two_d) : r_sum;
               idx_in = idx_ff + LEN_W'(1);
               if (fill_end) begin
                  state_in = ST_GOOD;
               end
            end
         end

         ST_GOOD: begin
            if (out_free) begin
               emit                    = 1'b1;
               emit_rsp.value          = smp_ff;
               emit_rsp.run_last       = 1'b1;
               emit_rsp.recording_done = end_ff;
               pend_in                 = '0;
               anchor_in               = end_ff ? '0 : smp_ff;
               seen_in                 = !end_ff;
               state_in                = ST_IDLE;
            end
         end

         ST_FLUSH_RD: begin
            state_in = ST_FLUSH;
         end

         ST_FLUSH: begin
            if (out_free) begin
               emit              = 1'b1;
               emit_rsp.value    = seen_ff ? anchor_ff : mem_q_ff;
               emit_rsp.replaced = seen_ff;
               idx_in            = idx_ff + LEN_W'(1);
               state_in          = ST_FLUSH_RD;
               if (flush_end) begin
                  emit_rsp.run_last       = stored_ff || !end_ff;
                  emit_rsp.recording_done = stored_ff;
                  pend_in                 = '0;
                  idx_in                  = '0;
                  if (stored_ff) begin
                     // recording closed: start over
                     anchor_in = '0;
                     seen_in   = 1'b0;
                     state_in  = ST_IDLE;
                  end else begin
                     state_in  = ST_STORE;
                  end
               end
            end
         end

         ST_STORE: begin
            mem_we    = 1'b1;
            pend_in   = pend_ff + LEN_W'(1);
            stored_in = 1'b1;
            idx_in    = '0;
            state_in  = end_ff ? ST_FLUSH_RD : ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      tally_inc = (emit_rsp.replaced && (tally_ff != TALLY_MAX)) ?
                  (tally_ff + TALLY_W'(1)) : tally_ff;
      if (emit) begin
         tally_in = emit_rsp.recording_done ? '0 : tally_inc;
         emit_rsp.replaced_total = emit_rsp.recording_done ? tally_inc : '0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         anchor_ff    <= '0;
         seen_ff      <= 1'b0;
         pend_ff      <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         anchor_ff    <= anchor_in;
         seen_ff      <= seen_in;
         pend_ff      <= pend_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      smp_ff     <= smp_in;
      end_ff     <= end_in;
      stored_ff  <= stored_in;
      rising_ff  <= rising_in;
      idx_ff     <= idx_in;
      den_ff     <= den_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_cnt_ff <= div_cnt_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      rsp_ff     <= rsp_in;
   end

   // gap memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pend_ff[ADDR_W-1:0]] <= smp_ff;
      end
      if (state_ff == ST_FLUSH_RD) begin
         mem_q_ff <= mem[idx_ff[ADDR_W-1:0]];
      end
   end

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= LEN_W'(GAP_DEPTH))
      else $error("gap length beyond store depth");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.recording_done |-> rsp_ff.run_last)
      else $error("recording end without run end");

   a_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.recording_done |-> rsp_ff.replaced_total == '0)
      else $error("tally shown before recording end");

   a_anchor_clear: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> anchor_ff == '0)
      else $error("anchor value without anchor");

   a_fill_between: assert property (@(posedge clock) disable iff (reset)
      emit && (state_ff == ST_FILL) && seen_ff |->
         ((emit_rsp.value >= anchor_ff && emit_rsp.value <= smp_ff) ||
          (emit_rsp.value <= anchor_ff && emit_rsp.value >= smp_ff)))
      else $error("interpolated value outside anchor and sample");

endmodule

@@ tb/sv/tb_heart_rate_spike_repair.sv @@
// ---------------------------------------------------------------------------
// tb_heart_rate_spike_repair: self-checking testbench for the spike repair
// Drives raw heart-rate requests under bursty flow control, predicts every
// repaired sample from an in-house model of the gap repair, and checks each
// result field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_heart_rate_spike_repair;
   timeunit 1ns;
   timeprecision 1ps;

   import hrsr_pkg::*;

   localparam int  SETTLE_CYCLES = 16;
   localparam int  CYCLE_LIMIT   = 3_000_000;
   localparam int  RANDOM_ITEMS  = 80;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_SLOW, STALL_RARE} stall_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] sample
   logic        req_tlast  = 1'b0; // stream_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [7:0] value, [23:8] replaced_total
   logic [1:0]  rsp_tuser;         // [0] replaced, [1] recording_done
   logic        rsp_tlast;         // run_last
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [7:0]  csr_tdata  = '0;   // upper_limit

   heart_rate_spike_repair dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // repair model state
   rate_type     limit_reg   = LIMIT_RESET;
   rate_type     hold_anchor = '0;
   bit           have_anchor = 1'b0;
   int           gap_len     = 0;
   rate_type     gap_store[GAP_DEPTH];
   logic [15:0]  fill_count  = '0;

   rsp_type      step_q[$];
   rsp_type      repaired_q[$];

   int             fail_count  = 0;
   int             cycle_count = 0;
   int             burst_left  = 0;
   int             hold_cycles = 0;
   int             random_sent = 0;
   bit             tx_steady   = 1'b0;
   stall_kind_type stall_kind  = STALL_NONE;
   int             stall_tick  = 0;

   // ------------------------------------------------------------------ model

   function automatic rate_type interp_fill(rate_type a, rate_type s, int j, int d);
      int mag;
      int q;
      if (s >= a) begin
         mag = j * (int'(s) - int'(a));
         q = (2 * mag + d) / (2 * d);
         return rate_type'(int'(a) + q);
      end
      mag = j * (int'(a) - int'(s));
      q = (2 * mag + d) / (2 * d);
      return rate_type'(int'(a) - q);
   endfunction

   function automatic void add_result(rate_type v, bit rep);
      rsp_type r;
      r = '0;
      r.value = v;
      r.replaced = rep;
      step_q.push_back(r);
      if (rep && fill_count != TALLY_MAX)
         fill_count++;
   endfunction

   // holds of the anchor, or the raw samples when no anchor exists
   function automatic void flush_gap();
      for (int i = 0; i < gap_len; i++) begin
         if (have_anchor)
            add_result(hold_anchor, 1'b1);
         else
            add_result(gap_store[i], 1'b0);
      end
      gap_len = 0;
   endfunction

   function automatic void predict_repair(rate_type smp, bit last);
      bit good;
      int n;
      good = (smp != 0) && (smp <= limit_reg);
      step_q = {};
      if (good) begin
         n = gap_len;
         for (int i = 0; i < n; i++)
            add_result(have_anchor ? interp_fill(hold_anchor, smp, i + 1, n + 1) : smp, 1'b1);
         gap_len = 0;
         add_result(smp, 1'b0);
         hold_anchor = smp;
         have_anchor = 1'b1;
      end else begin
         if (gap_len >= GAP_DEPTH)
            flush_gap();
         gap_store[gap_len] = smp;
         gap_len++;
      end
      if (last) begin
         flush_gap();
         step_q[$].recording_done = 1'b1;
         step_q[$].replaced_total = fill_count;
         hold_anchor = '0;
         have_anchor = 1'b0;
         fill_count = '0;
      end
      if (step_q.size() > 0) begin
         step_q[$].run_last = 1'b1;
         foreach (step_q[i])
            repaired_q.push_back(step_q[i]);
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void note_mismatch(string field, int want, int got);
      fail_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value          = rsp_tdata[7:0];
         got.replaced_total = rsp_tdata[23:8];
         got.replaced       = rsp_tuser[0];
         got.recording_done = rsp_tuser[1];
         got.run_last       = rsp_tlast;
         if (repaired_q.size() == 0) begin
            note_mismatch("unexpected result value", -1, int'(got.value));
         end else begin
            want = repaired_q.pop_front();
            if (got.value !== want.value)
               note_mismatch("value", int'(want.value), int'(got.value));
            if (got.replaced !== want.replaced)
               note_mismatch("replaced", int'(want.replaced), int'(got.replaced));
            if (got.run_last !== want.run_last)
               note_mismatch("run_last", int'(want.run_last), int'(got.run_last));
            if (got.recording_done !== want.recording_done)
               note_mismatch("recording_done", int'(want.recording_done),
                             int'(got.recording_done));
            if (got.replaced_total !== want.replaced_total)
               note_mismatch("replaced_total", int'(want.replaced_total),
                             int'(got.replaced_total));
         end
      end
   end

   // receiver: long hold-off when asked, otherwise a changing stall pattern
   always @(posedge clock) begin : rsp_stall
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         stall_tick++;
         if (stall_tick % 48 == 0)
            stall_kind = stall_kind_type'($urandom_range(0, 3));
         case (stall_kind)
            STALL_NONE: rsp_tready <= 1'b1;
            STALL_COIN: rsp_tready <= 1'($urandom_range(0, 1));
            STALL_SLOW: rsp_tready <= (stall_tick % 4 == 0);
            default:    rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_sample(input rate_type smp, input bit last);
      int gap;
      if (!tx_steady && burst_left == 0) begin
         gap = $urandom_range(1, 5);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0)
         burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_repair(smp, last);
   endtask

   // drain all outstanding results so the block is idle again
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (repaired_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input rate_type lim);
      csr_tvalid <= 1'b1;
      csr_tdata  <= lim;
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      limit_reg = lim;
   endtask

   function automatic rate_type pick_good();
      if (limit_reg == 0)
         return rate_type'($urandom_range(0, 255));
      return rate_type'($urandom_range(1, limit_reg));
   endfunction

   function automatic rate_type pick_bad();
      if (limit_reg == 8'd255 || $urandom_range(0, 2) == 0)
         return '0;
      return rate_type'($urandom_range(int'(limit_reg) + 1, 255));
   endfunction

   // ------------------------------------------------------------------ tests

   task automatic test_directed_basic();
      finish_phase();
      write_limit(8'd200);
      // leading bad samples copy the first good value
      send_sample(8'd0,   1'b0);
      send_sample(8'd201, 1'b0);
      send_sample(8'd1,   1'b0);
      // interpolation up to the limit itself
      send_sample(8'd255, 1'b0);
      send_sample(8'd0,   1'b0);
      send_sample(8'd200, 1'b0);
      // rounding half away from zero, rising then falling
      send_sample(8'd10,  1'b0);
      send_sample(8'd0,   1'b0);
      send_sample(8'd11,  1'b0);
      send_sample(8'd0,   1'b0);
      send_sample(8'd10,  1'b0);
      // a single bad sample is interpolated before the closing good sample
      send_sample(8'd230, 1'b0);
      send_sample(8'd7,   1'b1);
      // recording of one bad sample, no anchor
      send_sample(8'd0,   1'b1);
      // recording of one good sample
      send_sample(8'd50,  1'b1);
      // all bad, come out unchanged
      send_sample(8'd250, 1'b0);
      send_sample(8'd0,   1'b0);
      send_sample(8'd255, 1'b1);
      finish_phase();
   endtask

   task automatic test_limit_extremes();
      // zero limit: nothing is good
      write_limit(8'd0);
      send_sample(8'd1,   1'b0);
      send_sample(8'd255, 1'b0);
      send_sample(8'd0,   1'b1);
      finish_phase();
      write_limit(8'd255);
      send_sample(8'd255, 1'b0);
      send_sample(8'd0,   1'b0);
      send_sample(8'd1,   1'b1);
      finish_phase();
      write_limit(8'd1);
      send_sample(8'd1,   1'b0);
      send_sample(8'd2,   1'b0);
      send_sample(8'd1,   1'b1);
      finish_phase();
      write_limit(8'd200);
   endtask

   task automatic test_gap_overflow();
      // full store with no anchor flushes unchanged; ending on a full store
      // gives the most results from one request
      repeat (GAP_DEPTH) send_sample(pick_bad(), 1'b0);
      send_sample(pick_bad(), 1'b1);
      // full store with an anchor flushes as holds
      send_sample(8'd120, 1'b0);
      repeat (GAP_DEPTH + 1) send_sample(pick_bad(), 1'b0);
      // refill the store for the widest interpolation
      repeat (GAP_DEPTH - 1) send_sample(pick_bad(), 1'b0);
      send_sample(8'd60, 1'b0);
      finish_phase();
   endtask

   task automatic test_backpressure();
      tx_steady = 1'b1;
      hold_cycles = 500;
      send_sample(8'd90, 1'b0);
      for (int i = 0; i < 40; i++)
         send_sample((i % 5 == 4) ? rate_type'($urandom_range(60, 180)) : pick_bad(),
                     i == 39);
      tx_steady = 1'b0;
      finish_phase();
   endtask

   task automatic test_random();
      rate_type lim;
      int       gap;
      int       rec_len;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0:       lim = 8'd0;
            1:       lim = 8'd1;
            2:       lim = 8'd255;
            3:       lim = 8'd200;
            default: lim = rate_type'($urandom_range(2, 254));
         endcase
         finish_phase();
         write_limit(lim);
         repeat ((lim == 0) ? 1 : $urandom_range(2, 4)) begin
            rec_len = $urandom_range(3, 20);
            for (int r = 0; r < rec_len; r++) begin
               if ($urandom_range(0, 99) < 40) begin
                  case ($urandom_range(0, 19))
                     0:       gap = $urandom_range(55, 70);
                     1, 2, 3: gap = $urandom_range(7, 40);
                     default: gap = $urandom_range(1, 6);
                  endcase
                  repeat (gap) begin
                     send_sample(pick_bad(), 1'b0);
                     random_sent++;
                  end
               end
               // some noise and a few stray end marks
               send_sample(($urandom_range(0, 9) == 0) ? rate_type'($urandom_range(0, 255))
                                                       : pick_good(),
                           (r == rec_len - 1) || ($urandom_range(0, 99) == 0));
               random_sent++;
            end
            // sometimes the recording ends inside a gap
            if ($urandom_range(0, 2) == 0) begin
               repeat ($urandom_range(0, 5)) begin
                  send_sample(pick_bad(), 1'b0);
                  random_sent++;
               end
               send_sample(pick_bad(), 1'b1);
               random_sent++;
            end
         end
      end
      finish_phase();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_basic();
      test_limit_extremes();
      test_gap_overflow();
      test_backpressure();
      test_random();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/hrsr_pkg.sv
hdl/heart_rate_spike_repair.sv
tb/sv/tb_heart_rate_spike_repair.sv
